FILE: rtl/csem_pkg.sv
`default_nettype none

package csem_pkg;

   // Sizing of the block
   localparam int QUEUE_DEPTH = 16;
   localparam int PERMIT_BITS = 16;
   localparam int ID_BITS     = 8;

   // Fixed field widths of the ports
   localparam int FUNC_BITS  = 2;
   localparam int WID_BITS   = 8;
   localparam int CNT_BITS   = 16;
   localparam int EVENT_BITS = 3;

   // Derived widths
   localparam int IDX_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_BITS  = ((PERMIT_BITS > CNT_BITS) ? PERMIT_BITS : CNT_BITS) + 1;

   // Request function codes
   typedef enum logic [FUNC_BITS-1:0] {
      FN_TRY     = 2'd0,
      FN_WAIT    = 2'd1,
      FN_RELEASE = 2'd2,
      FN_CLOSE   = 2'd3
   } csem_func_type;

   // Result event codes
   typedef enum logic [EVENT_BITS-1:0] {
      EV_OK            = 3'd0,
      EV_NOT_ENOUGH    = 3'd1,
      EV_CLOSED        = 3'd2,
      EV_QUEUED        = 3'd3,
      EV_FULL_SAT      = 3'd4,
      EV_GRANTED       = 3'd5,
      EV_WAITER_CLOSED = 3'd6
   } csem_event_type;

   // Commands from controller to datapath
   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_CFG,
      CMD_LOAD,
      CMD_ACQ_ACK,
      CMD_REL_PART,
      CMD_REL_GRANT,
      CMD_REL_ACK,
      CMD_CLOSE_POP,
      CMD_PLAIN_ACK
   } csem_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic out_free;      // output register can take a word this cycle
      logic fill_zero;     // wait queue empty
      logic left_zero;     // nothing left of the release
      logic head_partial;  // head waiter wants more than is left
   } csem_status_type;

endpackage

`default_nettype wire

FILE: rtl/csem_dp.sv
`default_nettype none

module csem_dp
   import csem_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire csem_cmd_type          cmd,
   output csem_status_type            status,
   input  wire logic [FUNC_BITS-1:0]  req_func,
   input  wire logic [WID_BITS-1:0]   req_waiter_id,
   input  wire logic [CNT_BITS-1:0]   req_count,
   input  wire logic [CNT_BITS-1:0]   csr_wdata,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [EVENT_BITS-1:0]      rsp_event_res,
   output logic [WID_BITS-1:0]        rsp_target_id,
   output logic [CNT_BITS-1:0]        rsp_permits_now,
   output logic                       rsp_closed_now,
   output logic                       rsp_last
);

   // Semaphore state
   logic [PERMIT_BITS-1:0] free_ff, free_in;
   logic                   closed_ff, closed_in;
   logic [IDX_BITS-1:0]    head_ff, head_in;
   logic [IDX_BITS-1:0]    tail_ff, tail_in;
   logic [FILL_BITS-1:0]   fill_ff, fill_in;

   // Wait queue storage
   logic [ID_BITS-1:0]     queue_ids_ff   [QUEUE_DEPTH];
   logic [CNT_BITS-1:0]    queue_wants_ff [QUEUE_DEPTH];

   // Current word
   csem_func_type          func_ff, func_in;
   logic [WID_BITS-1:0]    id_ff, id_in;
   logic [CNT_BITS-1:0]    left_ff, left_in;

   // Output register
   logic                   rsp_valid_ff, rsp_valid_in;
   csem_event_type         rsp_event_ff, rsp_event_in;
   logic [WID_BITS-1:0]    rsp_id_ff, rsp_id_in;
   logic [CNT_BITS-1:0]    rsp_permits_ff, rsp_permits_in;
   logic                   rsp_closed_ff, rsp_closed_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   enq;
   logic                   part_wr;
   logic                   emit;
   logic                   out_free;
   logic [CNT_BITS-1:0]    want_head;
   logic [IDX_BITS-1:0]    head_step;
   logic [IDX_BITS-1:0]    tail_step;
   logic [SUM_BITS-1:0]    rel_sum;
   logic [SUM_BITS-1:0]    permit_max;
   logic                   queue_full;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign want_head  = queue_wants_ff[head_ff];
   assign head_step  = (head_ff == IDX_BITS'(QUEUE_DEPTH - 1)) ? '0 : head_ff + IDX_BITS'(1);
   assign tail_step  = (tail_ff == IDX_BITS'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + IDX_BITS'(1);
   assign rel_sum    = SUM_BITS'(free_ff) + SUM_BITS'(left_ff);
   assign permit_max = SUM_BITS'({PERMIT_BITS{1'b1}});
   assign queue_full = (fill_ff == FILL_BITS'(QUEUE_DEPTH));

   assign status.out_free     = out_free;
   assign status.fill_zero    = (fill_ff == '0);
   assign status.left_zero    = (left_ff == '0);
   assign status.head_partial = (want_head > left_ff);

   // Next-state logic per command
   always_comb begin
      free_in        = free_ff;
      closed_in      = closed_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      fill_in        = fill_ff;
      func_in        = func_ff;
      id_in          = id_ff;
      left_in        = left_ff;
      enq            = 1'b0;
      part_wr        = 1'b0;
      emit           = 1'b0;
      rsp_event_in   = EV_OK;
      rsp_id_in      = id_ff;
      rsp_last_in    = 1'b1;
      case (cmd)
         CMD_CFG: begin
            free_in   = PERMIT_BITS'(csr_wdata);
            closed_in = 1'b0;
            head_in   = '0;
            tail_in   = '0;
            fill_in   = '0;
         end
         CMD_LOAD: begin
            func_in = csem_func_type'(req_func);
            id_in   = req_waiter_id;
            left_in = req_count;
            if (csem_func_type'(req_func) == FN_CLOSE) begin
               closed_in = 1'b1;
            end
         end
         CMD_ACQ_ACK: begin
            emit = 1'b1;
            if (closed_ff) begin
               rsp_event_in = EV_CLOSED;
            end else if (SUM_BITS'(free_ff) >= SUM_BITS'(left_ff)) begin
               free_in      = free_ff - PERMIT_BITS'(left_ff);
               rsp_event_in = EV_OK;
            end else if (func_ff == FN_TRY) begin
               rsp_event_in = EV_NOT_ENOUGH;
            end else if (queue_full) begin
               rsp_event_in = EV_FULL_SAT;
            end else begin
               enq          = 1'b1;
               tail_in      = tail_step;
               fill_in      = fill_ff + FILL_BITS'(1);
               rsp_event_in = EV_QUEUED;
            end
         end
         CMD_REL_PART: begin
            part_wr = 1'b1;
            left_in = '0;
         end
         CMD_REL_GRANT: begin
            emit         = 1'b1;
            left_in      = left_ff - want_head;
            head_in      = head_step;
            fill_in      = fill_ff - FILL_BITS'(1);
            rsp_event_in = EV_GRANTED;
            rsp_id_in    = WID_BITS'(queue_ids_ff[head_ff]);
            rsp_last_in  = 1'b0;
         end
         CMD_REL_ACK: begin
            emit = 1'b1;
            if (rel_sum > permit_max) begin
               free_in      = {PERMIT_BITS{1'b1}};
               rsp_event_in = EV_FULL_SAT;
            end else begin
               free_in = PERMIT_BITS'(rel_sum);
            end
         end
         CMD_CLOSE_POP: begin
            emit         = 1'b1;
            head_in      = head_step;
            fill_in      = fill_ff - FILL_BITS'(1);
            rsp_event_in = EV_WAITER_CLOSED;
            rsp_id_in    = WID_BITS'(queue_ids_ff[head_ff]);
            rsp_last_in  = 1'b0;
         end
         CMD_PLAIN_ACK: begin
            emit = 1'b1;
         end
         default: begin
         end
      endcase
      // permits and closed flag as they stand after this word
      rsp_permits_in = CNT_BITS'(free_in);
      rsp_closed_in  = closed_in;
      rsp_valid_in   = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff      <= '0;
         closed_ff    <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         free_ff      <= free_in;
         closed_ff    <= closed_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      func_ff <= func_in;
      id_ff   <= id_in;
      left_ff <= left_in;
      if (emit) begin
         rsp_event_ff   <= rsp_event_in;
         rsp_id_ff      <= rsp_id_in;
         rsp_permits_ff <= rsp_permits_in;
         rsp_closed_ff  <= rsp_closed_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

   // Queue writes: enqueue at tail, partial payment at head
   always_ff @(posedge clock) begin
      if (enq) begin
         queue_ids_ff[tail_ff]   <= ID_BITS'(id_ff);
         queue_wants_ff[tail_ff] <= left_ff;
      end else if (part_wr) begin
         queue_wants_ff[head_ff] <= want_head - left_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_res   = rsp_event_ff;
   assign rsp_target_id   = rsp_id_ff;
   assign rsp_permits_now = rsp_permits_ff;
   assign rsp_closed_now  = rsp_closed_ff;
   assign rsp_last        = rsp_last_ff;

   // Checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_BITS'(QUEUE_DEPTH))
      else $error("queue fill beyond depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty queue with head and tail apart");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result word overwritten before taken");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_REL_GRANT || cmd == CMD_CLOSE_POP) |-> (fill_ff != '0))
      else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: rtl/csem_ctrl.sv
`default_nettype none

module csem_ctrl
   import csem_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [FUNC_BITS-1:0]  req_func,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire csem_status_type       status,
   output csem_cmd_type               cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ACQ   = 4'b0010,
      ST_REL   = 4'b0100,
      ST_CLOSE = 4'b1000
   } csem_state_type;

   csem_state_type state_ff, state_in;

   assign csr_ready = (state_ff == ST_IDLE);
   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               cmd = CMD_CFG;
            end else if (req_valid) begin
               cmd = CMD_LOAD;
               case (csem_func_type'(req_func))
                  FN_TRY, FN_WAIT: state_in = ST_ACQ;
                  FN_RELEASE:      state_in = ST_REL;
                  default:         state_in = ST_CLOSE;
               endcase
            end
         end
         ST_ACQ: begin
            if (status.out_free) begin
               cmd      = CMD_ACQ_ACK;
               state_in = ST_IDLE;
            end
         end
         ST_REL: begin
            // pay head waiters one per cycle while the output register is free, then fold leftover into count
            if (!status.left_zero && !status.fill_zero) begin
               if (status.head_partial) begin
                  cmd = CMD_REL_PART;
               end else if (status.out_free) begin
                  cmd = CMD_REL_GRANT;
               end
            end else if (status.out_free) begin
               cmd      = CMD_REL_ACK;
               state_in = ST_IDLE;
            end
         end
         ST_CLOSE: begin
            // wake every waiter, then acknowledge
            if (status.out_free) begin
               if (!status.fill_zero) begin
                  cmd = CMD_CLOSE_POP;
               end else begin
                  cmd      = CMD_PLAIN_ACK;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Checks
   a_part_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_REL_PART) |=> status.left_zero)
      else $error("partial payment left a remainder");

   a_load_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_LOAD) |=> (state_ff != ST_IDLE))
      else $error("word accepted but sequencer stayed idle");

   a_cfg_only_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_CFG) |=> (state_ff == ST_IDLE))
      else $error("config write started a sequence");

endmodule

`default_nettype wire

FILE: rtl/counting_semaphore_fifo_waiters.sv
`default_nettype none

// Counting semaphore with a FIFO wait queue of 16 waiters. Each request word
// (acquire-try, acquire-or-wait, release, close) yields one or more result
// words, the last of which is the acknowledge with rsp_last high. Each request
// is loaded and ends in its acknowledge; between the two, a release grants each
// waiter paid in full and pays the head in part if it wants more than is left,
// and a close wakes each waiter. The queue is read one entry a cycle at its
// head, and each result word waits for rsp_ready to free the output register.
// The next request is taken as soon as the acknowledge sits in the output
// register. Writing csr_wdata loads the permit count and empties the queue;
// the write is taken only between requests.
module counting_semaphore_fifo_waiters
   import csem_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [FUNC_BITS-1:0]  req_func,
   input  wire logic [WID_BITS-1:0]   req_waiter_id,
   input  wire logic [CNT_BITS-1:0]   req_count,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [EVENT_BITS-1:0]      rsp_event_res,
   output logic [WID_BITS-1:0]        rsp_target_id,
   output logic [CNT_BITS-1:0]        rsp_permits_now,
   output logic                       rsp_closed_now,
   output logic                       rsp_last,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CNT_BITS-1:0]   csr_wdata
);

   csem_cmd_type    cmd;
   csem_status_type status;

   csem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   csem_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_func        (req_func),
      .req_waiter_id   (req_waiter_id),
      .req_count       (req_count),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_res   (rsp_event_res),
      .rsp_target_id   (rsp_target_id),
      .rsp_permits_now (rsp_permits_now),
      .rsp_closed_now  (rsp_closed_now),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

FILE: bench/tb.sv
module tb;
   import csem_pkg::*;

   localparam int CLK_HALF     = 6;
   localparam int RESET_CYCLES = 8;
   localparam int RANDOM_ITEMS = 375;
   localparam int LONG_HOLD    = 300;
   localparam int STALL_LIMIT  = 2000;
   localparam int SHOW_LIMIT   = 10;
   localparam longint unsigned PERMIT_TOP = (64'd1 << PERMIT_BITS) - 1;

   // Random episode flavors
   localparam int EP_CONTEND  = 0;
   localparam int EP_PILE     = 1;
   localparam int EP_NOISE    = 2;
   localparam int EP_SATURATE = 3;

   // One result word as seen on the rsp_ channel
   typedef struct packed {
      csem_event_type        ev;
      logic [WID_BITS-1:0]   target;
      logic [CNT_BITS-1:0]   permits;
      logic                  closed;
      logic                  last;
   } sem_word_type;

   // Semaphore predictor plus the queue of result words it expects
   class sem_scoreboard_type;
      sem_word_type           expected[$];
      longint unsigned        avail;
      bit                     shut;
      logic [ID_BITS-1:0]     waiter_ids[$];
      longint unsigned        waiter_need[$];
      int                     errors;

      function new();
         avail  = 0;
         shut   = 1'b0;
         errors = 0;
      endfunction

      function int pending();
         return expected.size();
      endfunction

      // Register write: reload count, flush waiters, reopen
      function void load_permits(logic [CNT_BITS-1:0] value);
         avail = 64'(value) & PERMIT_TOP;
         shut  = 1'b0;
         waiter_ids.delete();
         waiter_need.delete();
      endfunction

      function void post(csem_event_type ev, logic [WID_BITS-1:0] id, bit last);
         sem_word_type w;
         w.ev      = ev;
         w.target  = id;
         w.permits = avail[CNT_BITS-1:0];
         w.closed  = shut;
         w.last    = last;
         expected.push_back(w);
      endfunction

      // Accepted request word: update state, queue the words it causes
      function void note_request(csem_func_type fn, logic [WID_BITS-1:0] wid,
                                 logic [CNT_BITS-1:0] cnt);
         csem_event_type  ev;
         longint unsigned left;
         ev = EV_OK;
         case (fn)
            FN_TRY, FN_WAIT: begin
               if (shut) begin
                  ev = EV_CLOSED;
               end else if (avail >= cnt) begin
                  avail = avail - cnt;
               end else if (fn == FN_TRY) begin
                  ev = EV_NOT_ENOUGH;
               end else if (waiter_ids.size() >= QUEUE_DEPTH) begin
                  ev = EV_FULL_SAT;
               end else begin
                  waiter_ids.push_back(wid[ID_BITS-1:0]);
                  waiter_need.push_back(64'(cnt));
                  ev = EV_QUEUED;
               end
            end
            FN_RELEASE: begin
               left = 64'(cnt);
               // pay the head in order; a partial payment stays with the head
               while (left > 0 && waiter_ids.size() > 0) begin
                  if (waiter_need[0] > left) begin
                     waiter_need[0] = waiter_need[0] - left;
                     left = 0;
                  end else begin
                     left = left - waiter_need[0];
                     void'(waiter_need.pop_front());
                     post(EV_GRANTED, waiter_ids.pop_front(), 1'b0);
                  end
               end
               if (left > PERMIT_TOP - avail) begin
                  avail = PERMIT_TOP;
                  ev = EV_FULL_SAT;
               end else begin
                  avail = avail + left;
               end
            end
            default: begin
               // only the first close wakes the waiters
               if (!shut) begin
                  shut = 1'b1;
                  while (waiter_ids.size() > 0) begin
                     void'(waiter_need.pop_front());
                     post(EV_WAITER_CLOSED, waiter_ids.pop_front(), 1'b0);
                  end
               end
            end
         endcase
         post(ev, wid, 1'b1);
      endfunction

      // Accepted result word: compare with the oldest expectation
      function void check_response(sem_word_type got);
         sem_word_type want;
         if (expected.size() == 0) begin
            errors++;
            if (errors <= SHOW_LIMIT)
               $display("unexpected word: ev=%0d id=%0d permits=%0d closed=%0b last=%0b",
                        got.ev, got.target, got.permits, got.closed, got.last);
            return;
         end
         want = expected.pop_front();
         if (got.ev !== want.ev || got.target !== want.target ||
             got.permits !== want.permits || got.closed !== want.closed ||
             got.last !== want.last) begin
            errors++;
            if (errors <= SHOW_LIMIT)
               $display("mismatch: exp ev=%0d id=%0d permits=%0d closed=%0b last=%0b %s",
                        want.ev, want.target, want.permits, want.closed, want.last,
                        $sformatf("got ev=%0d id=%0d permits=%0d closed=%0b last=%0b",
                                  got.ev, got.target, got.permits, got.closed,
                                  got.last));
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [FUNC_BITS-1:0]   req_func = '0;
   logic [WID_BITS-1:0]    req_waiter_id = '0;
   logic [CNT_BITS-1:0]    req_count = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [EVENT_BITS-1:0]  rsp_event_res;
   logic [WID_BITS-1:0]    rsp_target_id;
   logic [CNT_BITS-1:0]    rsp_permits_now;
   logic                   rsp_closed_now;
   logic                   rsp_last;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CNT_BITS-1:0]    csr_wdata = '0;

   sem_scoreboard_type sb;
   sem_word_type  seen_word;
   int            items_sent = 0;
   int            burst_left = 0;
   int            hold_asked = 0;
   int            hold_done = 0;
   int            hold_left = 0;
   int            rx_mode = 0;
   int            rx_mode_left = 0;
   int            rx_phase = 0;
   int            quiet_cycles = 0;

   counting_semaphore_fifo_waiters i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_waiter_id   (req_waiter_id),
      .req_count       (req_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_res   (rsp_event_res),
      .rsp_target_id   (rsp_target_id),
      .rsp_permits_now (rsp_permits_now),
      .rsp_closed_now  (rsp_closed_now),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #CLK_HALF;
      clock = 1'b1;
      #CLK_HALF;
      clock = 1'b0;
   end

   // Bus monitor; everything here is sampled before the edge takes effect
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            seen_word.ev      = csem_event_type'(rsp_event_res);
            seen_word.target  = rsp_target_id;
            seen_word.permits = rsp_permits_now;
            seen_word.closed  = rsp_closed_now;
            seen_word.last    = rsp_last;
            sb.check_response(seen_word);
         end
         if (req_valid && req_ready)
            sb.note_request(csem_func_type'(req_func), req_waiter_id, req_count);
         if (csr_valid && csr_ready)
            sb.load_permits(csr_wdata);
      end
   end

   // Receiver: changing stall patterns, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (hold_asked != hold_done) begin
         hold_done++;
         hold_left = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(8, 60);
         end
         rx_mode_left--;
         rx_phase++;
         case (rx_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 1) == 1);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (rx_phase % 3 != 0);
         endcase
      end
   end

   // Watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Offer one request word; sender runs in bursts with random gaps
   task automatic offer_word(csem_func_type fn, logic [WID_BITS-1:0] wid,
                             logic [CNT_BITS-1:0] cnt);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_func      <= fn;
      req_waiter_id <= wid;
      req_count     <= cnt;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Stop sending and wait until every expected word has come back
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_permits(logic [CNT_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [CNT_BITS-1:0] pick_count();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return CNT_BITS'($urandom);
         default: return CNT_BITS'($urandom_range(1, 12));
      endcase
   endfunction

   function automatic logic [WID_BITS-1:0] pick_id();
      return WID_BITS'($urandom_range(0, 255));
   endfunction

   // One random phase: fresh permit count, then a run of requests
   task automatic random_episode(int ep);
      int kind, len, k, roll;
      logic [CNT_BITS-1:0] permits;
      roll = $urandom_range(0, 9);
      kind = (roll < 4) ? EP_CONTEND : (roll < 7) ? EP_PILE :
             (roll < 9) ? EP_NOISE : EP_SATURATE;
      if (kind == EP_PILE) begin
         permits = CNT_BITS'($urandom_range(0, 4));
      end else begin
         case ($urandom_range(0, 4))
            0: permits = '0;
            1: permits = '1;
            2, 3: permits = CNT_BITS'($urandom_range(0, 24));
            default: permits = CNT_BITS'($urandom);
         endcase
      end
      write_permits(permits);
      // long receiver hold-off while requests keep coming
      if (ep == 2 || ep == 9)
         hold_asked++;
      len = (kind == EP_PILE) ? $urandom_range(22, 40) : $urandom_range(12, 40);
      for (k = 0; k < len; k++) begin
         roll = $urandom_range(0, 99);
         case (kind)
            EP_CONTEND: begin
               if (roll < 25)
                  offer_word(FN_TRY, pick_id(), pick_count());
               else if (roll < 60)
                  offer_word(FN_WAIT, pick_id(), pick_count());
               else if (roll < 97)
                  offer_word(FN_RELEASE, pick_id(), pick_count());
               else
                  offer_word(FN_CLOSE, pick_id(), CNT_BITS'($urandom));
            end
            EP_PILE: begin
               // fill past the queue depth, then pay out, then close
               if (k == len - 1)
                  offer_word(FN_CLOSE, pick_id(), CNT_BITS'($urandom));
               else if (k < 20 || roll < 10)
                  offer_word(FN_WAIT, pick_id(), CNT_BITS'($urandom_range(5, 40)));
               else if (roll < 25)
                  offer_word(FN_TRY, pick_id(), CNT_BITS'($urandom_range(0, 6)));
               else
                  offer_word(FN_RELEASE, pick_id(), CNT_BITS'($urandom_range(1, 40)));
            end
            EP_NOISE: begin
               offer_word(csem_func_type'($urandom_range(0, 3)), pick_id(),
                          CNT_BITS'($urandom));
            end
            default: begin
               if (roll < 60)
                  offer_word(FN_RELEASE, pick_id(),
                             (roll < 30) ? CNT_BITS'($urandom) :
                                           CNT_BITS'(16'hFFFF - $urandom_range(0, 8)));
               else
                  offer_word(csem_func_type'($urandom_range(0, 1)),
                             pick_id(), CNT_BITS'($urandom));
            end
         endcase
      end
      if (kind == EP_CONTEND && $urandom_range(0, 1) == 1)
         offer_word(FN_CLOSE, pick_id(), pick_count());
      drain();
   endtask

   initial begin
      int target, ep;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: acquire, partial pay, grant, saturation on an open semaphore
      write_permits(16'd3);
      offer_word(FN_TRY, 8'd0, 16'd0);
      offer_word(FN_TRY, 8'd255, 16'hFFFF);
      offer_word(FN_TRY, 8'h5A, 16'd2);
      offer_word(FN_WAIT, 8'hA5, 16'd4);
      offer_word(FN_RELEASE, 8'd1, 16'd1);
      offer_word(FN_TRY, 8'd2, 16'd1);
      offer_word(FN_RELEASE, 8'd3, 16'd0);
      offer_word(FN_RELEASE, 8'd4, 16'd3);
      offer_word(FN_RELEASE, 8'd5, 16'hFFFF);
      offer_word(FN_RELEASE, 8'd6, 16'd1);
      offer_word(FN_WAIT, 8'd7, 16'd0);
      offer_word(FN_CLOSE, 8'd8, 16'd0);
      drain();

      // Directed: close with waiters, second close, use after close
      write_permits(16'd0);
      offer_word(FN_WAIT, 8'h10, 16'd1);
      offer_word(FN_WAIT, 8'h11, 16'd2);
      offer_word(FN_WAIT, 8'h12, 16'd3);
      offer_word(FN_WAIT, 8'h13, 16'd4);
      offer_word(FN_TRY, 8'h14, 16'd1);
      offer_word(FN_CLOSE, 8'h20, 16'hFFFF);
      offer_word(FN_CLOSE, 8'h21, 16'd0);
      offer_word(FN_TRY, 8'h22, 16'd0);
      offer_word(FN_WAIT, 8'h23, 16'd5);
      offer_word(FN_RELEASE, 8'h24, 16'hFFFF);
      offer_word(FN_RELEASE, 8'h25, 16'd1);
      drain();

      // Random phases
      target = items_sent + RANDOM_ITEMS;
      ep = 0;
      while (items_sent < target) begin
         random_episode(ep);
         ep++;
      end

      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/csem_pkg.sv
rtl/csem_dp.sv
rtl/csem_ctrl.sv
rtl/counting_semaphore_fifo_waiters.sv
bench/tb.sv
